@@ sv/lpld_pkg.sv @@
`timescale 1ns / 1ps

package lpld_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_W     = 12;
    localparam int POS_W        = 13;
    localparam int ERR_W        = 14;
    localparam int CTRL_W       = 16;
    localparam int DUTY_W       = 8;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_REFERENCE = 2'd0,
        CFG_DEADBAND  = 2'd1,
        CFG_BASE_DUTY = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg_index;

    localparam logic signed [POS_W-1:0] RST_REFERENCE = 13'sd0;
    localparam logic [11:0]             RST_DEADBAND  = 12'd256;
    localparam logic [DUTY_W-1:0]       RST_BASE_DUTY = 8'd60;
    localparam logic [SAMPLE_W-1:0]     RST_THRESHOLD = 12'd2048;

    // Lead-lag coefficients scaled by 2^16.
    localparam logic signed [17:0] COEF_B0 = 18'sd101161;
    localparam logic signed [17:0] COEF_B1 = 18'sd96639;
    localparam logic signed [17:0] COEF_A1 = 18'sd55555;

    // Pipeline strobes handed from the sequencer to the datapath.
    typedef struct packed {
        logic lane_load;
        logic merge_load;
        logic mul_load;
        logic sum_load;
    } t_ctl;

    // Line bits to position in Q5.8: single bits and adjacent pairs, from the
    // rightmost sensor at -8.75 to the leftmost at +8.75 in steps of 1.25.
    function automatic logic signed [POS_W-1:0] pos_of(input logic [SENSOR_COUNT-1:0] pat);
        logic signed [POS_W-1:0] p;
        case (pat)
            8'h01:   p = -13'sd2240;
            8'h03:   p = -13'sd1920;
            8'h02:   p = -13'sd1600;
            8'h06:   p = -13'sd1280;
            8'h04:   p = -13'sd960;
            8'h0C:   p = -13'sd640;
            8'h08:   p = -13'sd320;
            8'h18:   p = 13'sd0;
            8'h10:   p = 13'sd320;
            8'h30:   p = 13'sd640;
            8'h20:   p = 13'sd960;
            8'h60:   p = 13'sd1280;
            8'h40:   p = 13'sd1600;
            8'hC0:   p = 13'sd1920;
            8'h80:   p = 13'sd2240;
            default: p = 13'sd0;
        endcase
        return p;
    endfunction

endpackage

@@ sv/lpld_lane.sv @@
`timescale 1ns / 1ps

module lpld_lane
    import lpld_pkg::*;
(
    input  logic                i_clk,
    input  t_ctl                i_ctl,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_threshold,
    output logic                o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.lane_load) begin
            r_bit <= (i_sample >= i_threshold);
        end
    end

    assign o_bit = r_bit;

endmodule

@@ sv/lpld_merge.sv @@
`timescale 1ns / 1ps

module lpld_merge
    import lpld_pkg::*;
(
    input  logic                    i_clk,
    input  t_ctl                    i_ctl,
    input  logic [SENSOR_COUNT-1:0] i_bits,
    input  logic signed [POS_W-1:0] i_reference,
    input  logic [11:0]             i_deadband,
    output logic signed [POS_W-1:0] o_position,
    output logic signed [ERR_W-1:0] o_error
);

    logic signed [POS_W-1:0] n_position;
    logic signed [ERR_W-1:0] w_diff;
    logic [ERR_W-1:0]        w_mag;
    logic signed [ERR_W-1:0] n_error;
    logic signed [POS_W-1:0] r_position;
    logic signed [ERR_W-1:0] r_error;

    always_comb begin
        n_position = pos_of(i_bits);
        w_diff     = ERR_W'(n_position) - ERR_W'(i_reference);
        w_mag      = w_diff[ERR_W-1] ? ERR_W'(-w_diff) : ERR_W'(w_diff);
        // Inside the deadband the error is treated as exactly zero.
        n_error    = (w_mag < ERR_W'(i_deadband)) ? '0 : w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.merge_load) begin
            r_position <= n_position;
            r_error    <= n_error;
        end
    end

    assign o_position = r_position;
    assign o_error    = r_error;

endmodule

@@ sv/lpld_law.sv @@
`timescale 1ns / 1ps

module lpld_law
    import lpld_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic signed [ERR_W-1:0]  i_error,
    input  logic [DUTY_W-1:0]        i_base_duty,
    output logic signed [CTRL_W-1:0] o_control,
    output logic [DUTY_W-1:0]        o_duty_left,
    output logic [DUTY_W-1:0]        o_duty_right
);

    localparam int ACC_W  = 36;
    localparam int DUTY_Q = 26;

    logic signed [ERR_W-1:0]  r_last_error;
    logic signed [CTRL_W-1:0] r_last_control;
    logic signed [31:0]       r_pb0;
    logic signed [31:0]       r_pb1;
    logic signed [33:0]       r_pa1;
    logic signed [CTRL_W-1:0] r_u;

    logic signed [ACC_W-1:0]  w_acc;
    logic signed [19:0]       w_round;
    logic signed [CTRL_W-1:0] n_u;
    logic signed [DUTY_Q-1:0] w_u_q;
    logic signed [DUTY_Q-1:0] w_us;
    logic signed [DUTY_Q-1:0] w_base;

    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [DUTY_Q-1:0] q);
        logic [DUTY_W-1:0] d;
        if (q < 0) begin
            d = '0;
        end else if (q > DUTY_Q'(65280)) begin
            d = '1;
        end else begin
            d = q[15:8];
        end
        return d;
    endfunction

    always_comb begin
        w_acc   = ACC_W'(r_pb0) - ACC_W'(r_pb1) + ACC_W'(r_pa1) + ACC_W'(32768);
        w_round = w_acc[ACC_W-1:16];
        if (w_round > 20'sd32767) begin
            n_u = 16'sh7FFF;
        end else if (w_round < -20'sd32768) begin
            n_u = -16'sh8000;
        end else begin
            n_u = w_round[CTRL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_load) begin
            r_pb0 <= 32'(i_error) * 32'(COEF_B0);
            r_pb1 <= 32'(r_last_error) * 32'(COEF_B1);
            r_pa1 <= 34'(r_last_control) * 34'(COEF_A1);
        end
        if (i_ctl.sum_load) begin
            r_u <= n_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error   <= '0;
            r_last_control <= '0;
        end else if (i_ctl.sum_load) begin
            r_last_error   <= i_error;
            r_last_control <= n_u;
        end
    end

    // u*255 is taken as u*256 - u.
    always_comb begin
        w_u_q  = DUTY_Q'(r_u);
        w_us   = (w_u_q <<< 8) - w_u_q;
        w_base = $signed(DUTY_Q'({i_base_duty, 8'h00}));
    end

    assign o_control    = r_u;
    assign o_duty_left  = (i_error == '0) ? '0 : sat_duty(w_base - w_us);
    assign o_duty_right = (i_error == '0) ? '0 : sat_duty(w_base + w_us);

endmodule

@@ sv/line_position_lead_lag_drive_top.sv @@
`timescale 1ns / 1ps
// Line follower drive: each item holds eight 12-bit reflectance samples. Eight
// threshold lanes turn them into line bits, a merge stage decodes the position
// and the deadbanded error, and a lead-lag unit computes the saturated control
// value u and the two motor duties. One item is worked on at a time. The
// threshold lanes load at the accepting edge. After that come decode and
// error, then the three coefficient products, then the sum, rounding and
// saturation of u, and then the duty mapping into the result register. The
// sequencer then returns to idle before it takes the next item. The wait for
// the next item stretches while a finished result cannot move into the result
// register. The result register is separate, so the next item is taken while
// a result waits. Configuration registers are read while an item is in flight,
// so a write takes effect on the next item only if it is made while idle; the
// block itself does not enforce this.

module line_position_lead_lag_drive_top
    import lpld_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [12:0]              i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SAMPLE_W-1:0]      i_sample_0,
    input  logic [SAMPLE_W-1:0]      i_sample_1,
    input  logic [SAMPLE_W-1:0]      i_sample_2,
    input  logic [SAMPLE_W-1:0]      i_sample_3,
    input  logic [SAMPLE_W-1:0]      i_sample_4,
    input  logic [SAMPLE_W-1:0]      i_sample_5,
    input  logic [SAMPLE_W-1:0]      i_sample_6,
    input  logic [SAMPLE_W-1:0]      i_sample_7,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [POS_W-1:0]  o_position,
    output logic signed [ERR_W-1:0]  o_error,
    output logic signed [CTRL_W-1:0] o_control,
    output logic                     o_direction,
    output logic [DUTY_W-1:0]        o_duty_left,
    output logic [DUTY_W-1:0]        o_duty_right
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    t_state r_state;

    logic signed [POS_W-1:0] r_reference;
    logic [11:0]             r_deadband;
    logic [DUTY_W-1:0]       r_base_duty;
    logic [SAMPLE_W-1:0]     r_threshold;

    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_position;
    logic signed [ERR_W-1:0]  r_error;
    logic signed [CTRL_W-1:0] r_control;
    logic                     r_direction;
    logic [DUTY_W-1:0]        r_duty_left;
    logic [DUTY_W-1:0]        r_duty_right;

    t_ctl                     w_ctl;
    logic                     w_accept;
    logic                     w_out_free;
    logic [SAMPLE_W-1:0]      w_samp [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0]  w_bits;
    logic signed [POS_W-1:0]  w_position;
    logic signed [ERR_W-1:0]  w_error;
    logic signed [CTRL_W-1:0] w_control;
    logic [DUTY_W-1:0]        w_duty_left;
    logic [DUTY_W-1:0]        w_duty_right;

    assign w_samp[0] = i_sample_0;
    assign w_samp[1] = i_sample_1;
    assign w_samp[2] = i_sample_2;
    assign w_samp[3] = i_sample_3;
    assign w_samp[4] = i_sample_4;
    assign w_samp[5] = i_sample_5;
    assign w_samp[6] = i_sample_6;
    assign w_samp[7] = i_sample_7;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_ctl.lane_load  = w_accept;
    assign w_ctl.merge_load = (r_state == S_POS);
    assign w_ctl.mul_load   = (r_state == S_MUL);
    assign w_ctl.sum_load   = (r_state == S_SUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference <= RST_REFERENCE;
            r_deadband  <= RST_DEADBAND;
            r_base_duty <= RST_BASE_DUTY;
            r_threshold <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REFERENCE: r_reference <= $signed(i_cfg_data);
                CFG_DEADBAND:  r_deadband  <= i_cfg_data[11:0];
                CFG_BASE_DUTY: r_base_duty <= i_cfg_data[DUTY_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample 0 is the leftmost sensor and lands in the top pattern bit.
    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lpld_lane u_lane (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_sample    (w_samp[g]),
            .i_threshold (r_threshold),
            .o_bit       (w_bits[SENSOR_COUNT-1-g])
        );
    end

    lpld_merge u_merge (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_bits      (w_bits),
        .i_reference (r_reference),
        .i_deadband  (r_deadband),
        .o_position  (w_position),
        .o_error     (w_error)
    );

    lpld_law u_law (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_error      (w_error),
        .i_base_duty  (r_base_duty),
        .o_control    (w_control),
        .o_duty_left  (w_duty_left),
        .o_duty_right (w_duty_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (w_accept) r_state <= S_POS;
                S_POS:  r_state <= S_MUL;
                S_MUL:  r_state <= S_SUM;
                S_SUM:  r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_position   <= w_position;
            r_error      <= w_error;
            r_control    <= w_control;
            r_direction  <= !w_error[ERR_W-1];
            r_duty_left  <= w_duty_left;
            r_duty_right <= w_duty_right;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_position   = r_position;
    assign o_error      = r_error;
    assign o_control    = r_control;
    assign o_direction  = r_direction;
    assign o_duty_left  = r_duty_left;
    assign o_duty_right = r_duty_right;

endmodule

@@ sv/lpld_checker.sv @@
`timescale 1ns / 1ps

module lpld_checker
    import lpld_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_cfg_we,
    input logic [1:0]               i_cfg_index,
    input logic [12:0]              i_cfg_data,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [SAMPLE_W-1:0]      i_sample_0,
    input logic [SAMPLE_W-1:0]      i_sample_1,
    input logic [SAMPLE_W-1:0]      i_sample_2,
    input logic [SAMPLE_W-1:0]      i_sample_3,
    input logic [SAMPLE_W-1:0]      i_sample_4,
    input logic [SAMPLE_W-1:0]      i_sample_5,
    input logic [SAMPLE_W-1:0]      i_sample_6,
    input logic [SAMPLE_W-1:0]      i_sample_7,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [POS_W-1:0]  o_position,
    input logic signed [ERR_W-1:0]  o_error,
    input logic signed [CTRL_W-1:0] o_control,
    input logic                     o_direction,
    input logic [DUTY_W-1:0]        o_duty_left,
    input logic [DUTY_W-1:0]        o_duty_right
);

    // A result held under stall keeps its control, error and duty values.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_control)
            && $stable(o_error) && $stable(o_duty_left) && $stable(o_duty_right))
        else $error("result changed while stalled");

    // One item at a time: right after an item is taken the input is stalled.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in flight");

    // Zero error stops both motors with the direction bit set.
    a_zero_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error == '0 |-> o_direction && o_duty_left == '0
            && o_duty_right == '0)
        else $error("motors not stopped on zero error");

    // Direction follows the sign of the error.
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_direction == !o_error[ERR_W-1])
        else $error("direction does not match error sign");

endmodule

bind line_position_lead_lag_drive_top lpld_checker u_lpld_checker (.*);
